FILE: sv/lle_pkg.sv
// Shared types, codes and helper functions for the login line editor.
// No dependencies; imported by lle_seq, login_line_editor and the testbench.
package lle_pkg;

	localparam int NAME_CAPACITY_DEF = 50;
	localparam int CHAR_W            = 7;
	localparam int CFG_IDX_W         = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KILL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EOF   = 2'd2;

	localparam logic [CHAR_W-1:0] ERASE_RST = 7'd8;
	localparam logic [CHAR_W-1:0] KILL_RST  = 7'd21;
	localparam logic [CHAR_W-1:0] EOF_RST   = 7'd4;

	localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
	localparam logic [CHAR_W-1:0] CH_TAB = 7'h09;
	localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;
	localparam logic [CHAR_W-1:0] CH_FF  = 7'h0C;
	localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
	localparam logic [CHAR_W-1:0] CH_SP  = 7'h20;
	localparam logic [CHAR_W-1:0] CH_HASH = 7'h23;
	localparam logic [CHAR_W-1:0] CH_AT  = 7'h40;
	localparam logic [CHAR_W-1:0] CH_UA  = 7'h41;
	localparam logic [CHAR_W-1:0] CH_UZ  = 7'h5A;
	localparam logic [CHAR_W-1:0] CH_LA  = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LZ  = 7'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFS = 7'h20;

	typedef enum logic [2:0] {
		EV_CHAR     = 3'd0,
		EV_KILL     = 3'd1,
		EV_SPEED    = 3'd2,
		EV_EOF      = 3'd3,
		EV_REPROMPT = 3'd4
	} ev_kind_t;

	typedef enum logic [2:0] {
		CLS_SPEED,
		CLS_IGNORE,
		CLS_EOF,
		CLS_KILL,
		CLS_ERASE,
		CLS_END,
		CLS_STORE
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic [CHAR_W-1:0] erase_char;
		logic [CHAR_W-1:0] kill_char;
		logic [CHAR_W-1:0] eof_char;
	} cfg_regs_t;

	function automatic cls_t classify(input logic [CHAR_W-1:0] c, input cfg_regs_t cfg);
		cls_t r;
		priority if (c == CH_NUL)                          r = CLS_SPEED;
		else if (c == CH_SP || c == CH_TAB || c == CH_FF)  r = CLS_IGNORE;
		else if (c == cfg.eof_char)                        r = CLS_EOF;
		else if (c == cfg.kill_char || c == CH_AT)         r = CLS_KILL;
		else if (c == cfg.erase_char || c == CH_HASH)      r = CLS_ERASE;
		else if (c == CH_LF || c == CH_CR)                 r = CLS_END;
		else                                               r = CLS_STORE;
		return r;
	endfunction

	function automatic logic is_upper(input logic [CHAR_W-1:0] c);
		return (c >= CH_UA) && (c <= CH_UZ);
	endfunction

	function automatic logic is_lower(input logic [CHAR_W-1:0] c);
		return (c >= CH_LA) && (c <= CH_LZ);
	endfunction

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
			input logic en);
		return (en && is_upper(c)) ? c + CASE_OFS : c;
	endfunction

endpackage

FILE: sv/lle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lle_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 50,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/lle_seq.sv
// Character classifier, line state and readout sequencer of the login line editor.
// Depends on lle_pkg; drives the name store held in an lle_ram instance.
module lle_seq
	import lle_pkg::*;
#(
	parameter int NAME_CAPACITY = NAME_CAPACITY_DEF,
	localparam int AW = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1,
	localparam int LW = $clog2(NAME_CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_regs_t         cfg,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  logic [7:0]        rx_byte,
	output logic              ev_valid,
	input  logic              ev_stall,
	output logic [2:0]        event_kind,
	output logic [CHAR_W-1:0] name_char,
	output logic              last_of_run,
	output logic              cr_ended,
	output logic              case_folded,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [CHAR_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr,
	input  logic [CHAR_W-1:0] ram_rdata
);

	state_t            state_q, state_d;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     idx_q;
	logic              up_q, lo_q;
	logic              cr_q, fold_q;

	logic              out_valid_q;
	ev_kind_t          kind_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q, cr_out_q, fold_out_q;

	logic [CHAR_W-1:0] c;
	cls_t              cls;
	logic              slot_free;
	logic              accept;
	logic              last_idx;
	logic              send;
	logic              line_empty;

	assign c          = rx_byte[CHAR_W-1:0];
	assign cls        = classify(c, cfg);
	assign slot_free  = !out_valid_q || !ev_stall;
	assign line_empty = (len_q == '0);
	assign last_idx   = ((idx_q + LW'(1)) == len_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cls == CLS_END && !line_empty) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_SEND;
			ST_SEND: begin
				if (slot_free) state_d = last_idx ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		rx_stall  = 1'b1;
		ram_re    = 1'b0;
		send      = 1'b0;
		unique case (state_q)
			ST_IDLE:  rx_stall = !slot_free;
			ST_FETCH: ram_re   = 1'b1;
			ST_SEND:  send     = slot_free;
			default:  rx_stall = 1'b1;
		endcase
	end

	assign accept    = rx_valid && !rx_stall;
	assign ram_raddr = idx_q[AW-1:0];
	assign ram_waddr = len_q[AW-1:0];
	assign ram_wdata = c;
	assign ram_we    = accept && cls == CLS_STORE && (len_q < LW'(NAME_CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			up_q        <= 1'b0;
			lo_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (!ev_stall) out_valid_q <= 1'b0;
			if (accept) begin
				unique case (cls)
					CLS_SPEED, CLS_EOF, CLS_KILL: begin
						len_q       <= '0;
						up_q        <= 1'b0;
						lo_q        <= 1'b0;
						out_valid_q <= 1'b1;
					end
					CLS_ERASE: begin
						if (!line_empty) len_q <= len_q - LW'(1);
					end
					CLS_END: begin
						if (line_empty) begin
							up_q        <= 1'b0;
							lo_q        <= 1'b0;
							out_valid_q <= 1'b1;
						end
						idx_q <= '0;
					end
					CLS_STORE: begin
						if (is_upper(c)) up_q <= 1'b1;
						else if (is_lower(c)) lo_q <= 1'b1;
						if (ram_we) len_q <= len_q + LW'(1);
					end
					default: ;
				endcase
			end
			if (send) begin
				out_valid_q <= 1'b1;
				if (last_idx) begin
					len_q <= '0;
					up_q  <= 1'b0;
					lo_q  <= 1'b0;
				end else begin
					idx_q <= idx_q + LW'(1);
				end
			end
		end
	end

	// result payload and per-name flags
	always_ff @(posedge clk) begin
		if (accept && cls == CLS_END) begin
			cr_q   <= (c == CH_CR);
			fold_q <= up_q && !lo_q;
		end
		if (accept) begin
			char_q     <= '0;
			last_q     <= 1'b1;
			cr_out_q   <= 1'b0;
			fold_out_q <= 1'b0;
			unique case (cls)
				CLS_SPEED: kind_q <= EV_SPEED;
				CLS_EOF:   kind_q <= EV_EOF;
				CLS_KILL:  kind_q <= EV_KILL;
				default:   kind_q <= EV_REPROMPT;
			endcase
		end
		if (send) begin
			kind_q     <= EV_CHAR;
			char_q     <= fold_char(ram_rdata, fold_q);
			last_q     <= last_idx;
			cr_out_q   <= cr_q;
			fold_out_q <= fold_q;
		end
	end

	assign ev_valid    = out_valid_q;
	assign event_kind  = kind_q;
	assign name_char   = char_q;
	assign last_of_run = last_q;
	assign cr_ended    = cr_out_q;
	assign case_folded = fold_out_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(NAME_CAPACITY))
		else $error("line length beyond capacity");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> rx_stall)
		else $error("input taken during readout");

	a_idx_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> idx_q < len_q)
		else $error("readout index past end of line");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		send && last_idx |=> len_q == '0 && state_q == ST_IDLE && ev_valid && last_of_run)
		else $error("final name character did not end the run");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		send |-> slot_free)
		else $error("result register overwritten while stalled");

endmodule

FILE: sv/login_line_editor.sv
// Top level of the login line editor: configuration registers, name store
// and sequencer. Depends on lle_pkg, lle_ram and lle_seq.
//
// Usage:
//   rx channel: rx_valid/rx_stall with rx_byte; a byte transfers when
//   rx_valid is high and rx_stall low. Only the low 7 bits are used.
//   ev channel: ev_valid/ev_stall with event_kind, name_char, last_of_run,
//   cr_ended and case_folded; a result transfers when ev_valid is high and
//   ev_stall low.
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//   ready. Index 0 erase, 1 kill, 2 end-of-file character; others ignored.
// Flow: a byte that gives one result (speed cycle, end of file, kill,
// reprompt) shows it in the output register the cycle after its transfer;
// a byte that is stored, erased or ignored gives no result and does not
// hold off the next byte. A line end with stored characters reads the name
// store one entry per fetch/send pair, and output stalls can hold the run;
// rx_stall stays high until the last character is in the output register.
// While the receiver stalls, the held result stays put and no new byte is
// taken. Reset empties the line and loads the default characters; the name
// store needs no clearing.
module login_line_editor
	import lle_pkg::*;
#(
	parameter int NAME_CAPACITY = NAME_CAPACITY_DEF,
	localparam int AW = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  logic [7:0]           rx_byte,
	output logic                 ev_valid,
	input  logic                 ev_stall,
	output logic [2:0]           event_kind,
	output logic [CHAR_W-1:0]    name_char,
	output logic                 last_of_run,
	output logic                 cr_ended,
	output logic                 case_folded,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CHAR_W-1:0]    cfg_data
);

	cfg_regs_t         cfg_q;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CHAR_W-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.erase_char <= ERASE_RST;
			cfg_q.kill_char  <= KILL_RST;
			cfg_q.eof_char   <= EOF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ERASE: cfg_q.erase_char <= cfg_data;
				CFG_KILL:  cfg_q.kill_char  <= cfg_data;
				CFG_EOF:   cfg_q.eof_char   <= cfg_data;
				default: ;
			endcase
		end
	end

	lle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (NAME_CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lle_seq #(
		.NAME_CAPACITY (NAME_CAPACITY)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.ev_valid    (ev_valid),
		.ev_stall    (ev_stall),
		.event_kind  (event_kind),
		.name_char   (name_char),
		.last_of_run (last_of_run),
		.cr_ended    (cr_ended),
		.case_folded (case_folded),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

endmodule

FILE: tb/login_line_editor_tb.sv
// Self-checking testbench for login_line_editor: line editing, erase and kill,
// name emission with case folding, and the three character registers.
// Depends on lle_pkg and the RTL of the block; nothing else.
module login_line_editor_tb;
	import lle_pkg::*;

	localparam int CAP = NAME_CAPACITY_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;	// unmapped register index

	typedef struct {
		ev_kind_t          kind;
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              cr;
		logic              fold;
	} ev_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 rx_valid = 1'b0;
	logic                 rx_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 ev_valid;
	logic                 ev_stall = 1'b0;
	logic [2:0]           event_kind;
	logic [CHAR_W-1:0]    name_char;
	logic                 last_of_run;
	logic                 cr_ended;
	logic                 case_folded;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CHAR_W-1:0]    cfg_data = '0;

	login_line_editor uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.ev_valid    (ev_valid),
		.ev_stall    (ev_stall),
		.event_kind  (event_kind),
		.name_char   (name_char),
		.last_of_run (last_of_run),
		.cr_ended    (cr_ended),
		.case_folded (case_folded),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// stimulus side
	logic [7:0] rx_items[$];
	int         queued_count = 0;
	logic [CHAR_W-1:0] cur_erase = ERASE_RST;
	logic [CHAR_W-1:0] cur_kill  = KILL_RST;
	logic [CHAR_W-1:0] cur_eof   = EOF_RST;

	// predictor state
	ev_item_t          expected_events[$];
	logic [CHAR_W-1:0] line_buf[CAP];
	int                line_len = 0;
	logic              line_upper = 1'b0;
	logic              line_lower = 1'b0;
	logic [CHAR_W-1:0] erase_reg = ERASE_RST;
	logic [CHAR_W-1:0] kill_reg  = KILL_RST;
	logic [CHAR_W-1:0] eof_reg   = EOF_RST;

	logic rx_fire = 1'b0;
	int   errors = 0;

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (errors < 50)
			$display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic void note_event(input ev_kind_t kind, input logic [CHAR_W-1:0] ch,
			input logic last, input logic cr, input logic fold);
		ev_item_t e;
		e.kind = kind;
		e.ch   = ch;
		e.last = last;
		e.cr   = cr;
		e.fold = fold;
		expected_events.push_back(e);
	endfunction

	function automatic void clear_name();
		line_len   = 0;
		line_upper = 1'b0;
		line_lower = 1'b0;
	endfunction

	// line editor prediction for one transferred byte
	function automatic void edit_line(input logic [7:0] b);
		logic [CHAR_W-1:0] c;
		logic [CHAR_W-1:0] ch;
		logic              fold;
		logic              cr;
		c = b[CHAR_W-1:0];
		if (c == CH_NUL) begin
			clear_name();
			note_event(EV_SPEED, '0, 1'b1, 1'b0, 1'b0);
		end else if (c == CH_SP || c == CH_TAB || c == CH_FF) begin
		end else if (c == eof_reg) begin
			clear_name();
			note_event(EV_EOF, '0, 1'b1, 1'b0, 1'b0);
		end else if (c == kill_reg || c == CH_AT) begin
			clear_name();
			note_event(EV_KILL, '0, 1'b1, 1'b0, 1'b0);
		end else if (c == erase_reg || c == CH_HASH) begin
			if (line_len > 0)
				line_len--;
		end else if (c == CH_LF || c == CH_CR) begin
			cr = (c == CH_CR);
			fold = line_upper && !line_lower;
			if (line_len == 0) begin
				note_event(EV_REPROMPT, '0, 1'b1, 1'b0, 1'b0);
			end else begin
				for (int i = 0; i < line_len; i++) begin
					ch = line_buf[i];
					if (fold && ch >= CH_UA && ch <= CH_UZ)
						ch = ch + CASE_OFS;
					note_event(EV_CHAR, ch, i == line_len - 1, cr, fold);
				end
			end
			clear_name();
		end else begin
			if (c >= CH_UA && c <= CH_UZ)
				line_upper = 1'b1;
			else if (c >= CH_LA && c <= CH_LZ)
				line_lower = 1'b1;
			// letters past capacity still mark the line
			if (line_len < CAP) begin
				line_buf[line_len] = c;
				line_len++;
			end
		end
	endfunction

	task automatic check_event();
		ev_item_t e;
		if (expected_events.size() == 0) begin
			report_mismatch("unexpected result, kind", {5'd0, event_kind}, 8'h00);
		end else begin
			e = expected_events.pop_front();
			if (event_kind !== e.kind)
				report_mismatch("event_kind", {5'd0, event_kind}, {5'd0, e.kind});
			if (name_char !== e.ch)
				report_mismatch("name_char", {1'b0, name_char}, {1'b0, e.ch});
			if (last_of_run !== e.last)
				report_mismatch("last_of_run", {7'd0, last_of_run}, {7'd0, e.last});
			if (cr_ended !== e.cr)
				report_mismatch("cr_ended", {7'd0, cr_ended}, {7'd0, e.cr});
			if (case_folded !== e.fold)
				report_mismatch("case_folded", {7'd0, case_folded}, {7'd0, e.fold});
		end
	endtask

	// monitor: results first, then register writes and the incoming byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (ev_valid && !ev_stall)
				check_event();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ERASE: erase_reg = cfg_data;
					CFG_KILL:  kill_reg  = cfg_data;
					CFG_EOF:   eof_reg   = cfg_data;
					default: ;
				endcase
			end
			if (rx_valid && !rx_stall)
				edit_line(rx_byte);
		end
		rx_fire <= arst_n && rx_valid && !rx_stall;
	end

	// byte driver: bursts with gaps, payload held until transfer
	int gap_left = 0;
	int burst_left = 8;

	always @(negedge clk) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || rx_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				rx_valid <= 1'b0;
			end else if (rx_items.size() != 0) begin
				rx_valid <= 1'b1;
				rx_byte  <= rx_items.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 12);
					gap_left = $urandom_range(1, 6);
				end
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// result stall pattern: calm, scattered or in runs, switching now and then
	int stall_mode = 0;
	int mode_left = 100;
	int run_left = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(64, 256);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: ev_stall <= 1'b0;
			1: ev_stall <= ($urandom_range(0, 9) < 3);
			default: begin
				if (run_left > 0) begin
					run_left--;
					ev_stall <= 1'b1;
				end else begin
					run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
					ev_stall <= 1'b0;
				end
			end
		endcase
	end

	function automatic void queue_rx(input logic [7:0] b);
		rx_items.push_back(b);
		if (!(b[6:0] == CH_SP || b[6:0] == CH_TAB || b[6:0] == CH_FF))
			queued_count++;
	endfunction

	// top bit is discarded by the block, so set it at random
	function automatic void queue_char(input logic [CHAR_W-1:0] c);
		logic hi;
		hi = 1'($urandom_range(0, 1));
		queue_rx({hi, c});
	endfunction

	function automatic void queue_line();
		int                len;
		int                style;
		int                roll;
		logic [CHAR_W-1:0] c;
		roll = $urandom_range(0, 99);
		len = (roll < 80) ? $urandom_range(1, 8) : (roll < 95) ? $urandom_range(9, 20)
			: $urandom_range(45, 58);
		style = $urandom_range(0, 2);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: c = CHAR_W'($urandom_range(CH_UA, CH_UZ));
				1: c = CHAR_W'($urandom_range(CH_LA, CH_LZ));
				default: c = CHAR_W'($urandom_range(33, 126));
			endcase
			queue_char(c);
			roll = $urandom_range(0, 99);
			if (roll < 8)
				queue_char($urandom_range(0, 1) ? CH_HASH : cur_erase);
			else if (roll < 10)
				queue_char($urandom_range(0, 1) ? CH_AT : cur_kill);
		end
		roll = $urandom_range(0, 99);
		if (roll < 90)
			queue_char($urandom_range(0, 1) ? CH_CR : CH_LF);
		else if (roll < 94)
			queue_char(CH_NUL);
		else if (roll < 97)
			queue_char(cur_eof);
	endfunction

	function automatic void queue_random(input int count);
		int stop_at;
		int n;
		stop_at = queued_count + count;
		while (queued_count < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					queue_rx(8'($urandom_range(0, 255)));
			end else begin
				queue_line();
			end
		end
	endfunction

	task automatic wait_drained();
		int guard;
		guard = 0;
		@(posedge clk);
		while ((rx_items.size() != 0 || rx_valid || expected_events.size() != 0)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// trailing stores and erases give no result; let them finish
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ERASE: cur_erase = val;
			CFG_KILL:  cur_kill  = val;
			CFG_EOF:   cur_eof   = val;
			default: ;
		endcase
	endtask

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0] directed[$];
		directed = '{
			8'h00, 8'h80,                   // speed cycle, also with top bit set
			8'h20, 8'h09, 8'h0C,            // ignored
			8'h04,                          // end of file
			8'h0A,                          // empty line
			8'h08, 8'h23, 8'h0D,            // erase on empty line, then empty CR
			8'h41, 8'h42, 8'h8D,            // upper only, folded, CR
			8'h61, 8'h42, 8'h0A,            // mixed case, not folded
			8'h78, 8'h40, 8'h95,            // kill by '@' and by register
			8'h41, 8'h08, 8'h62, 8'h0A,     // erase keeps the upper mark
			8'hFF, 8'h7E, 8'h0D             // top of the character range
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			queue_rx(directed[i]);
		// overlong line: capacity reached, a late lower-case letter still counts
		for (int i = 0; i < CAP + 5; i++)
			queue_char(CHAR_W'($urandom_range(CH_UA, CH_UZ)));
		queue_char(CH_LA);
		queue_char(CH_LF);
		queue_random(20);
		wait_drained();

		// extremes; overlaps with fixed characters resolve in priority order
		write_reg(CFG_ERASE, 7'h7F);
		write_reg(CFG_KILL, 7'h00);
		write_reg(CFG_EOF, 7'h7F);
		queue_random(20);
		wait_drained();

		write_reg(CFG_ERASE, CH_LF);
		write_reg(CFG_KILL, CH_HASH);
		write_reg(CFG_EOF, CH_SP);
		write_reg(CFG_SPARE, CHAR_W'($urandom_range(0, 127)));
		queue_random(20);
		wait_drained();

		write_reg(CFG_ERASE, CHAR_W'($urandom_range(0, 127)));
		write_reg(CFG_KILL, CHAR_W'($urandom_range(0, 127)));
		write_reg(CFG_EOF, CHAR_W'($urandom_range(0, 127)));
		queue_random(20);
		wait_drained();

		if (expected_events.size() != 0)
			report_mismatch("results never seen, count", 8'(expected_events.size()), 8'h00);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
